[design/road_scanline_param_gen_assert.svh]
// ----------------------------------------------------------------------------
// Road scanline parameter generator assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROAD_SCANLINE_PARAM_GEN_ASSERT_SVH
`define ROAD_SCANLINE_PARAM_GEN_ASSERT_SVH

`ifndef SYNTH
`define RSG_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
`define RSG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSG_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg)
`define RSG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

[design/rsg_pkg.sv]
// ----------------------------------------------------------------------------
// Road scanline parameter generator package
// Beat payload types, register indexes, reset values and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rsg_pkg;

  typedef struct packed {
    logic [8:0]  line;
    logic [15:0] frame;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic               is_road;
    logic [7:0]         sky_red;
    logic [7:0]         tex_row;
    logic signed [15:0] tex_offset;
    logic [15:0]        depth;
    logic               palette_select;
  } out_item_t;

  typedef struct packed {
    logic signed [7:0]  curve_accel;
    logic [8:0]         horizon_line;
    logic [17:0]        altitude_rate_init;
    logic signed [10:0] altitude_accel;
    logic [7:0]         speed;
  } cfg_t;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [17:0] cfg_data_t;

  localparam cfg_idx_t CFG_CURVE_ACCEL    = 3'd0;
  localparam cfg_idx_t CFG_HORIZON_LINE   = 3'd1;
  localparam cfg_idx_t CFG_ALT_RATE_INIT  = 3'd2;
  localparam cfg_idx_t CFG_ALT_ACCEL      = 3'd3;
  localparam cfg_idx_t CFG_SPEED          = 3'd4;

  localparam logic signed [7:0]  RST_CURVE_ACCEL   = 8'sd0;
  localparam logic [8:0]         RST_HORIZON_LINE  = 9'd120;
  localparam logic [17:0]        RST_ALT_RATE_INIT = 18'd32768;
  localparam logic signed [10:0] RST_ALT_ACCEL     = 11'sd0;
  localparam logic [7:0]         RST_SPEED         = 8'd26;

  localparam logic [31:0] LAT_BASE   = 32'd2560;
  localparam logic [31:0] CURVE_GAIN = 32'd200;
  localparam int          LAT_SHIFT  = 7;
  localparam logic [31:0] ALT_CLAMP  = 32'h007F_8000;
  localparam logic [10:0] SKY_BIAS   = 11'd16;
  localparam logic [10:0] SKY_MAX    = 11'd255;
  localparam logic [8:0]  DIV_BIAS   = 9'd32;
  localparam logic [9:0]  DIV_REM_INIT = 10'd16;
  localparam int          DIV_STEPS  = 14;
  localparam int          MUL_STEPS  = 8;

endpackage

`default_nettype wire

[design/rsg_if.sv]
// ----------------------------------------------------------------------------
// Road scanline parameter generator channels
// Valid/ready interfaces for line beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsg_in_if;
  logic             valid;
  logic             ready;
  rsg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsg_out_if;
  logic               valid;
  logic               ready;
  rsg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsg_cfg_if;
  logic               valid;
  logic               ready;
  rsg_pkg::cfg_idx_t  index;
  rsg_pkg::cfg_data_t wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[design/rsg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Road scanline parameter generator register file
// Holds the five control registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rsg_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  rsg_cfg_if.sink       cfg_chan,
  output rsg_pkg::cfg_t cfg_o
);

  rsg_pkg::cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg_o          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_accel        <= rsg_pkg::RST_CURVE_ACCEL;
      cfg_r.horizon_line       <= rsg_pkg::RST_HORIZON_LINE;
      cfg_r.altitude_rate_init <= rsg_pkg::RST_ALT_RATE_INIT;
      cfg_r.altitude_accel     <= rsg_pkg::RST_ALT_ACCEL;
      cfg_r.speed              <= rsg_pkg::RST_SPEED;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        rsg_pkg::CFG_CURVE_ACCEL:   cfg_r.curve_accel        <= cfg_chan.wdata[7:0];
        rsg_pkg::CFG_HORIZON_LINE:  cfg_r.horizon_line       <= cfg_chan.wdata[8:0];
        rsg_pkg::CFG_ALT_RATE_INIT: cfg_r.altitude_rate_init <= cfg_chan.wdata;
        rsg_pkg::CFG_ALT_ACCEL:     cfg_r.altitude_accel     <= cfg_chan.wdata[10:0];
        rsg_pkg::CFG_SPEED:         cfg_r.speed              <= cfg_chan.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/road_scanline_param_gen.sv]
// ----------------------------------------------------------------------------
// Road scanline parameter generator
// Per-line sky level or road texture row, column offset, depth and stripe.
// ----------------------------------------------------------------------------
// One line beat in, one result beat out. A sky result is registered as the
// beat is taken, then moved to the output register; for a road line one shared
// 32-bit adder steps the four Q15 accumulators, runs the restoring divide for
// 262144/(row+32), the shift-add frame*speed product and the two depth sums.
// The input side is busy while a line is in work; a finished result sits in
// the output register, so the next line is taken while it waits. Register
// writes are for the user to put between lines; the block does not enforce it.
`default_nettype none

`include "road_scanline_param_gen_assert.svh"

module road_scanline_param_gen (
  input  logic      clk,
  input  logic      rst_n,
  rsg_in_if.sink    in_chan,
  rsg_out_if.source out_chan,
  rsg_cfg_if.sink   cfg_chan
);

  typedef enum logic [3:0] {
    S_IDLE, S_ALT_RATE, S_ALT_POS, S_LAT_RATE, S_LAT_POS,
    S_DIV, S_MUL, S_BASE, S_STRIPE, S_DONE
  } state_t;

  rsg_pkg::cfg_t      cfg;
  state_t             state_r;
  logic [31:0]        lat_pos_r, lat_rate_r, alt_pos_r, alt_rate_r;
  logic [15:0]        frame_r;
  logic [7:0]         row_r;
  logic [9:0]         rem_r;
  logic [13:0]        quo_r;
  logic [15:0]        mot_r;
  logic [15:0]        base_r;
  logic [3:0]         cnt_r;
  rsg_pkg::out_item_t res_r;
  rsg_pkg::out_item_t out_r;
  logic               out_valid_r;

  logic        in_acc;
  logic        res_load;
  logic        is_sky;
  logic [10:0] red_sum;
  logic [7:0]  red;
  logic [31:0] curve_ext, aacc_ext, lat_init;
  logic [31:0] add_a, add_b, add_sum;
  logic        add_sub;
  logic [10:0] rem_sh;
  logic [8:0]  divisor;
  logic [15:0] mul_part;
  logic        alt_ovf;
  logic [16:0] lat_int;
  logic [15:0] tex_off;
  logic        sky_beat, road_beat, sky_clean;

  rsg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign res_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign is_sky   = in_chan.data.line < cfg.horizon_line;
  assign red_sum  = {1'b0, in_chan.data.line, 1'b0} + rsg_pkg::SKY_BIAS;
  assign red      = (red_sum > rsg_pkg::SKY_MAX) ? 8'hFF : red_sum[7:0];

  assign curve_ext = {{24{cfg.curve_accel[7]}}, cfg.curve_accel};
  assign aacc_ext  = {{21{cfg.altitude_accel[10]}}, cfg.altitude_accel};
  assign lat_init  = (rsg_pkg::LAT_BASE - curve_ext * rsg_pkg::CURVE_GAIN)
                     << rsg_pkg::LAT_SHIFT;

  assign rem_sh   = {rem_r, 1'b0};
  assign divisor  = {1'b0, row_r} + rsg_pkg::DIV_BIAS;
  assign mul_part = cfg.speed[cnt_r[2:0]] ? (frame_r << cnt_r[2:0]) : 16'd0;

  // shared adder / subtractor
  always_comb begin
    add_a   = 32'd0;
    add_b   = 32'd0;
    add_sub = 1'b0;
    unique case (state_r)
      S_ALT_RATE: begin
        add_a = alt_rate_r;
        add_b = aacc_ext;
      end
      S_ALT_POS: begin
        add_a = alt_pos_r;
        add_b = alt_rate_r;
      end
      S_LAT_RATE: begin
        add_a = lat_rate_r;
        add_b = curve_ext;
      end
      S_LAT_POS: begin
        add_a = lat_pos_r;
        add_b = lat_rate_r;
      end
      S_DIV: begin
        add_a   = {21'd0, rem_sh};
        add_b   = {23'd0, divisor};
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_a = {16'd0, mot_r};
        add_b = {16'd0, mul_part};
      end
      S_BASE: begin
        add_a = {18'd0, quo_r};
        add_b = {16'd0, mot_r};
      end
      S_STRIPE: begin
        add_a = {16'd0, base_r};
        add_b = {16'd0, mot_r};
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};
  assign alt_ovf = !add_sum[31] && (add_sum[30:23] != 8'd0);

  assign lat_int = lat_pos_r[31:15];
  assign tex_off = (lat_int[16] != lat_int[15]) ?
                   (lat_int[16] ? 16'h8000 : 16'h7FFF) : lat_int[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lat_pos_r   <= 32'd0;
      lat_rate_r  <= 32'd0;
      alt_pos_r   <= 32'd0;
      alt_rate_r  <= 32'd0;
      cnt_r       <= 4'd0;
    end else begin
      if (res_load) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            frame_r <= in_chan.data.frame;
            if (in_chan.data.frame_start) begin
              lat_pos_r  <= lat_init;
              lat_rate_r <= 32'd0;
              alt_pos_r  <= 32'd0;
              alt_rate_r <= {14'd0, cfg.altitude_rate_init};
            end
            if (is_sky) begin
              res_r.is_road        <= 1'b0;
              res_r.sky_red        <= red;
              res_r.tex_row        <= 8'd0;
              res_r.tex_offset     <= 16'sd0;
              res_r.depth          <= 16'd0;
              res_r.palette_select <= 1'b0;
              state_r              <= S_DONE;
            end else begin
              state_r <= S_ALT_RATE;
            end
          end
        end
        S_ALT_RATE: begin
          alt_rate_r <= add_sum;
          state_r    <= S_ALT_POS;
        end
        S_ALT_POS: begin
          alt_pos_r <= alt_ovf ? rsg_pkg::ALT_CLAMP : add_sum;
          state_r   <= S_LAT_RATE;
        end
        S_LAT_RATE: begin
          lat_rate_r <= add_sum;
          state_r    <= S_LAT_POS;
        end
        S_LAT_POS: begin
          lat_pos_r <= add_sum;
          row_r     <= alt_pos_r[31] ? 8'd0 : alt_pos_r[22:15];
          rem_r     <= rsg_pkg::DIV_REM_INIT;
          quo_r     <= 14'd0;
          cnt_r     <= 4'd0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r <= add_sum[31] ? rem_sh[9:0] : add_sum[9:0];
          quo_r <= {quo_r[12:0], !add_sum[31]};
          if (cnt_r == 4'(rsg_pkg::DIV_STEPS - 1)) begin
            cnt_r   <= 4'd0;
            mot_r   <= 16'd0;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_MUL: begin
          mot_r <= add_sum[15:0];
          if (cnt_r == 4'(rsg_pkg::MUL_STEPS - 1)) begin
            cnt_r   <= 4'd0;
            state_r <= S_BASE;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_BASE: begin
          base_r  <= add_sum[15:0];
          state_r <= S_STRIPE;
        end
        S_STRIPE: begin
          res_r.is_road        <= 1'b1;
          res_r.sky_red        <= 8'd0;
          res_r.tex_row        <= row_r;
          res_r.tex_offset     <= tex_off;
          res_r.depth          <= base_r;
          res_r.palette_select <= add_sum[9];
          state_r              <= S_STRIPE == S_STRIPE ? S_DONE : S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign sky_beat  = out_chan.valid && !out_chan.data.is_road;
  assign road_beat = out_chan.valid && out_chan.data.is_road;
  assign sky_clean = (out_chan.data.tex_row == 8'd0) && (out_chan.data.depth == 16'd0) &&
                     !out_chan.data.palette_select;

  `RSG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_chan.ready, "input taken twice")
  `RSG_ASSERT_NOW(a_sky_fields_zero, clk, rst_n, sky_beat, sky_clean, "sky beat has road fields")
  `RSG_ASSERT_NOW(a_road_no_sky, clk, rst_n, road_beat, out_chan.data.sky_red == 8'd0, "road sky")

endmodule

`default_nettype wire

[tb/road_scanline_param_gen_tb.sv]
// ----------------------------------------------------------------------------
// Road scanline parameter generator testbench
// Drives line beats and register writes, with random line and result gaps.
// A line-by-line model of the Q15 road accumulators predicts the result
// beats but those of typed table rows; each is compared field by field in
// order of arrival. The run covers reset values, register extremes, random
// settings and a long frame that drives the altitude into its upper clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module road_scanline_param_gen_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int SOAK_LINES  = 200;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    rsg_pkg::in_item_t  stim;
    logic               typed;
    rsg_pkg::out_item_t want;
  } dir_row_t;

  localparam rsg_pkg::out_item_t FROM_MODEL = '0;

  // typed rows hold results read straight off the reset settings
  localparam dir_row_t DIR_TAB [11] = '{
    '{'{9'd0,   16'h0000, 1'b0}, 1'b1, '{1'b0, 8'd16,  8'd0, 16'sd0, 16'd0,    1'b0}},
    '{'{9'd120, 16'h0000, 1'b0}, 1'b1, '{1'b1, 8'd0,   8'd0, 16'sd0, 16'd8192, 1'b0}},
    '{'{9'd119, 16'hFFFF, 1'b1}, 1'b1, '{1'b0, 8'd254, 8'd0, 16'sd0, 16'd0,    1'b0}},
    '{'{9'd1,   16'h00FF, 1'b0}, 1'b1, '{1'b0, 8'd18,  8'd0, 16'sd0, 16'd0,    1'b0}},
    '{'{9'd120, 16'hFFFF, 1'b0}, 1'b0, FROM_MODEL},
    '{'{9'd511, 16'h0000, 1'b0}, 1'b0, FROM_MODEL},
    '{'{9'd255, 16'h8000, 1'b0}, 1'b0, FROM_MODEL},
    '{'{9'd200, 16'h7FFF, 1'b1}, 1'b0, FROM_MODEL},
    '{'{9'd121, 16'hFF00, 1'b0}, 1'b0, FROM_MODEL},
    '{'{9'd511, 16'hAAAA, 1'b1}, 1'b0, FROM_MODEL},
    '{'{9'd256, 16'h5555, 1'b0}, 1'b0, FROM_MODEL}
  };

  logic clk = 1'b0;
  logic rst_n;

  rsg_in_if  in_if();
  rsg_out_if out_if();
  rsg_cfg_if cfg_if();

  road_scanline_param_gen dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #6 clk = ~clk;

  rsg_pkg::cfg_t      road_cfg;
  logic [31:0]        side_pos, side_vel, elev_pos, elev_vel;
  rsg_pkg::out_item_t line_params_q [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  bit                 idle_en = 1'b1;

  function automatic rsg_pkg::out_item_t predict_line(input rsg_pkg::in_item_t it);
    rsg_pkg::out_item_t r;
    logic [31:0]        curve32, accel32, motion, base, stripe, rowu;
    logic [10:0]        red;
    int                 row, col;
    r = '0;
    curve32 = {{24{road_cfg.curve_accel[7]}}, road_cfg.curve_accel};
    accel32 = {{21{road_cfg.altitude_accel[10]}}, road_cfg.altitude_accel};
    if (it.frame_start) begin
      side_pos = (32'd2560 - 32'd200 * curve32) * 32'd128;
      side_vel = '0;
      elev_pos = '0;
      elev_vel = {14'd0, road_cfg.altitude_rate_init};
    end
    if (it.line < road_cfg.horizon_line) begin
      red = {1'b0, it.line, 1'b0} + 11'd16;
      r.sky_red = (red > 11'd255) ? 8'd255 : red[7:0];
    end else begin
      elev_vel = elev_vel + accel32;
      elev_pos = elev_pos + elev_vel;
      if (($signed(elev_pos) >>> 15) > 255) elev_pos = 32'd255 << 15;
      side_vel = side_vel + curve32;
      side_pos = side_pos + side_vel;
      row = $signed(elev_pos) >>> 15;
      if (row < 0) row = 0;
      if (row > 255) row = 255;
      col = $signed(side_pos) >>> 15;
      if (col > 32767) col = 32767;
      if (col < -32768) col = -32768;
      motion = {16'd0, it.frame} * {24'd0, road_cfg.speed};
      rowu = row;
      base = 32'd262144 / (rowu + 32'd32) + motion;
      stripe = base + motion;
      r.is_road = 1'b1;
      r.tex_row = rowu[7:0];
      r.tex_offset = col[15:0];
      r.depth = base[15:0];
      r.palette_select = stripe[9];
    end
    return r;
  endfunction

  function automatic void check_field(input string what,
                                      input logic signed [31:0] want, got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_line(input rsg_pkg::in_item_t it, input logic typed,
                           input rsg_pkg::out_item_t want);
    rsg_pkg::out_item_t exp_item;
    while (idle_en && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    exp_item = predict_line(it);
    line_params_q.push_back(typed ? want : exp_item);
  endtask

  // every line beat yields a result beat, so an empty queue means idle
  task automatic wait_results_done();
    if (line_params_q.size() != 0) begin
      in_if.valid <= 1'b0;
      while (line_params_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input rsg_pkg::cfg_idx_t idx, input rsg_pkg::cfg_data_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      rsg_pkg::CFG_CURVE_ACCEL:   road_cfg.curve_accel        = val[7:0];
      rsg_pkg::CFG_HORIZON_LINE:  road_cfg.horizon_line       = val[8:0];
      rsg_pkg::CFG_ALT_RATE_INIT: road_cfg.altitude_rate_init = val;
      rsg_pkg::CFG_ALT_ACCEL:     road_cfg.altitude_accel     = val[10:0];
      rsg_pkg::CFG_SPEED:         road_cfg.speed              = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input rsg_pkg::cfg_data_t curve, horizon, alt_init,
                              alt_accel, spd);
    write_reg(rsg_pkg::CFG_CURVE_ACCEL, curve);
    write_reg(rsg_pkg::CFG_HORIZON_LINE, horizon);
    write_reg(rsg_pkg::CFG_ALT_RATE_INIT, alt_init);
    write_reg(rsg_pkg::CFG_ALT_ACCEL, alt_accel);
    write_reg(rsg_pkg::CFG_SPEED, spd);
    // unmapped index, must be dropped
    write_reg(rsg_pkg::cfg_idx_t'(rsg_pkg::CFG_SPEED + 1 + $urandom_range(2)),
              rsg_pkg::cfg_data_t'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    rsg_pkg::out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (line_params_q.size() == 0) begin
        $display("%0t unexpected result beat: actual %p", $time, out_if.data);
        mismatches++;
      end else begin
        want = line_params_q.pop_front();
        check_field("is_road", want.is_road, out_if.data.is_road);
        check_field("sky_red", want.sky_red, out_if.data.sky_red);
        check_field("tex_row", want.tex_row, out_if.data.tex_row);
        check_field("tex_offset", want.tex_offset, out_if.data.tex_offset);
        check_field("depth", want.depth, out_if.data.depth);
        check_field("palette_select", want.palette_select, out_if.data.palette_select);
      end
    end
    out_if.ready <= idle_en ? ($urandom_range(99) >= 12) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    rsg_pkg::in_item_t it;
    logic [15:0]       fr;
    logic [8:0]        ln;
    int                sent, len;
    road_cfg = '{rsg_pkg::RST_CURVE_ACCEL, rsg_pkg::RST_HORIZON_LINE,
                 rsg_pkg::RST_ALT_RATE_INIT, rsg_pkg::RST_ALT_ACCEL,
                 rsg_pkg::RST_SPEED};
    side_pos = '0;
    side_vel = '0;
    elev_pos = '0;
    elev_vel = '0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 11; i++) send_line(DIR_TAB[i].stim, DIR_TAB[i].typed, DIR_TAB[i].want);

    fr = 16'($urandom);
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      case (ph)
        0: program_regs(18'h00080, 18'd511, 18'd131072, 18'h00400, 18'd255);
        1: program_regs(18'd127, 18'd0, 18'h3FFFF, 18'd1023, 18'd0);
        2: program_regs(18'd0, 18'd0, 18'd0, 18'h00400, 18'd1);
        default: program_regs(rsg_pkg::cfg_data_t'($urandom), rsg_pkg::cfg_data_t'($urandom),
                              rsg_pkg::cfg_data_t'($urandom), rsg_pkg::cfg_data_t'($urandom),
                              rsg_pkg::cfg_data_t'($urandom));
      endcase
      idle_en = (ph != 4 && ph != 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          it.line        = 9'($urandom);
          it.frame       = 16'($urandom);
          it.frame_start = 1'($urandom);
          send_line(it, 1'b0, FROM_MODEL);
          sent++;
        end else begin
          if ($urandom_range(7) == 0) wait_results_done();
          fr++;
          ln = ($urandom_range(3) == 0) ? 9'd0
                                        : road_cfg.horizon_line - 9'($urandom_range(6));
          len = $urandom_range(8, 80);
          if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
          for (int i = 0; i < len; i++) begin
            it.line = ln;
            it.frame = fr;
            it.frame_start = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0);
            send_line(it, 1'b0, FROM_MODEL);
            sent++;
            ln = ln + (($urandom_range(29) == 0) ? 9'd2 : 9'd1);
          end
        end
      end
    end

    // one long frame: altitude climbs into its clamp and is held there
    wait_results_done();
    idle_en = 1'b1;
    program_regs(18'h3FF80, 18'd0, 18'h3FFFF, 18'h3FC00, rsg_pkg::cfg_data_t'($urandom));
    ln = '0;
    for (int i = 0; i < SOAK_LINES; i++) begin
      it.line = ln;
      it.frame = fr;
      it.frame_start = (i == 0);
      send_line(it, 1'b0, FROM_MODEL);
      ln++;
      if (ln == 9'd0) fr++;
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && line_params_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
